// File: design/ebcpu_pkg.sv
// ----------------------------------------------------------------------------
// ebcpu_pkg
// Shared types, opcode codes and stream field layout for the 8-bit CPU
// execute block and its checker.
// ----------------------------------------------------------------------------
package ebcpu_pkg;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 128;

  // Result tdata field offsets, lowest bit first
  localparam int unsigned O_PC    = 0;
  localparam int unsigned O_A     = 16;
  localparam int unsigned O_BC    = 24;
  localparam int unsigned O_DE    = 40;
  localparam int unsigned O_HL    = 56;
  localparam int unsigned O_SP    = 72;
  localparam int unsigned O_FLAGS = 88;
  localparam int unsigned O_CYC   = 92;
  localparam int unsigned O_ACC   = 96;
  localparam int unsigned O_ADDR  = 98;
  localparam int unsigned O_WDATA = 114;
  localparam int unsigned O_USED  = 122;

  // Memory access kind
  typedef enum logic [1:0] {
    MEM_NONE       = 2'd0,
    MEM_READ       = 2'd1,
    MEM_WRITE      = 2'd2,
    MEM_READ_WRITE = 2'd3
  } mem_access_e;

  // Cycle counts
  localparam logic [3:0] CYC_NONE = 4'd0;
  localparam logic [3:0] CYC_4    = 4'd4;
  localparam logic [3:0] CYC_8    = 4'd8;
  localparam logic [3:0] CYC_12   = 4'd12;

  // Opcodes and decode masks
  localparam logic [7:0] OP_NOP       = 8'h00;
  localparam logic [7:0] OP_HALT      = 8'h76;
  localparam logic [7:0] OP_JR        = 8'h18;
  localparam logic [7:0] OP_JR_NZ     = 8'h20;
  localparam logic [7:0] OP_JR_Z      = 8'h28;
  localparam logic [7:0] OP_JR_NC     = 8'h30;
  localparam logic [7:0] OP_JR_C      = 8'h38;
  localparam logic [7:0] MASK_PAIR    = 8'hCF;
  localparam logic [7:0] OP_LD_RR_D16 = 8'h01;
  localparam logic [7:0] OP_ST_RR_A   = 8'h02;
  localparam logic [7:0] OP_INC_RR    = 8'h03;
  localparam logic [7:0] OP_DEC_RR    = 8'h0B;
  localparam logic [7:0] MASK_INCDEC  = 8'hC6;
  localparam logic [7:0] OP_INCDEC_R  = 8'h04;
  localparam logic [7:0] MASK_LD_R    = 8'hC7;
  localparam logic [7:0] OP_LD_R_D8   = 8'h06;
  localparam logic [7:0] OP_XOR_FIRST = 8'hA8;
  localparam logic [7:0] OP_XOR_LAST  = 8'hAF;
  localparam logic [7:0] OP_LDH_C_A   = 8'hE2;
  localparam logic [7:0] OP_LDH_A_C   = 8'hF2;
  localparam logic [7:0] CB_BIT_FIRST = 8'h40;
  localparam logic [7:0] CB_BIT_LAST  = 8'h7F;

  localparam logic [15:0] IO_PAGE = 16'hFF00;

  // Register and pair indexes
  localparam logic [2:0] REG_B   = 3'd0;
  localparam logic [2:0] REG_C   = 3'd1;
  localparam logic [2:0] REG_D   = 3'd2;
  localparam logic [2:0] REG_E   = 3'd3;
  localparam logic [2:0] REG_H   = 3'd4;
  localparam logic [2:0] REG_L   = 3'd5;
  localparam logic [2:0] REG_MEM = 3'd6;
  localparam logic [2:0] REG_A   = 3'd7;

  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_SP = 2'd3;

  // Pick an 8-bit register; the memory operand index reads as zero
  function automatic logic [7:0] sel_reg(input logic [2:0] idx,
                                         input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c, input logic [7:0] d,
                                         input logic [7:0] e, input logic [7:0] h,
                                         input logic [7:0] l);
    logic [7:0] v;
    case (idx)
      REG_B:   v = b;
      REG_C:   v = c;
      REG_D:   v = d;
      REG_E:   v = e;
      REG_H:   v = h;
      REG_L:   v = l;
      REG_A:   v = a;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// File: design/eight_bit_cpu_execute_subset.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_subset
// Executes one instruction of an 8-bit CPU subset per input transaction and
// reports the register file, flags, memory access and cycle count.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                                   tuser
//  s_axis    in   operation, immediate, mem_read_data     cb_prefixed
//  m_axis    out  pc, a, bc, de, hl, sp, flags, cycles,   unknown_opcode
//                 mem_access, mem_address, mem_write_data
//
//  One instruction retires per clock unless m_axis stalls. A transaction is
//  captured in the input register, executed against the architectural
//  registers in one pass, and the result lands in the output register when
//  the input stage advances; the architectural state updates on that same
//  edge, so the next instruction sees it without a bubble.
//  Reset clears A, BC, DE, HL, flags, SP and PC and empties both stages.
//  A stall on m_axis holds the output register; one more transaction is
//  held in the input register before s_axis_tready drops.
//
module eight_bit_cpu_execute_subset (
  input  logic         clk_i,
  input  logic         rst_ni,
  // s_axis_tdata: operation [7:0], immediate [23:8], mem_read_data [31:24]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [ebcpu_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // s_axis_tuser: cb_prefixed
  input  logic         s_axis_tuser,
  // m_axis_tdata: out_pc [15:0], out_a [23:16], out_bc [39:24],
  //   out_de [55:40], out_hl [71:56], out_sp [87:72], out_flags [91:88],
  //   cycle_count [95:92], mem_access [97:96], mem_address [113:98],
  //   mem_write_data [121:114], zero [127:122]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [ebcpu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // m_axis_tuser: unknown_opcode
  output logic         m_axis_tuser
);

  // Input stage
  logic        in_valid_q;
  logic [7:0]  in_op_q;
  logic        in_cb_q;
  logic [15:0] in_imm_q;
  logic [7:0]  in_mrd_q;

  // Output stage
  logic                                  out_valid_q;
  logic [ebcpu_pkg::OUT_TDATA_W-1:0]     out_data_q;
  logic                                  out_unknown_q;

  // Architectural state
  logic [7:0]  a_q, b_q, c_q, d_q, e_q, h_q, l_q;
  logic [7:0]  a_d, b_d, c_d, d_d, e_d, h_d, l_d;
  logic [3:0]  flags_q, flags_d;   // {Z, N, H, C}
  logic [15:0] sp_q, sp_d, pc_q, pc_d;

  logic advance;

  // Decode / execute
  logic [2:0]  r_idx, src_idx;
  logic [1:0]  p_idx;
  logic [7:0]  imm8;
  logic [15:0] bc, de, hl, pair_rd, rel_off;
  logic        known, take_jump;
  logic [1:0]  pc_len;
  logic [3:0]  cycles;
  ebcpu_pkg::mem_access_e access;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [7:0]  operand, result8;
  logic        is_dec, half;
  logic        pw_en;
  logic [1:0]  pw_sel;
  logic [15:0] pw_val;
  logic        rw_en;
  logic [2:0]  rw_sel;
  logic [7:0]  rw_val;
  logic [7:0]  xor_res;

  // Advance when the input stage holds work and the output stage can take it
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign r_idx   = in_op_q[5:3];
  assign src_idx = in_op_q[2:0];
  assign p_idx   = in_op_q[5:4];
  assign imm8    = in_imm_q[7:0];
  assign bc      = {b_q, c_q};
  assign de      = {d_q, e_q};
  assign hl      = {h_q, l_q};
  assign rel_off = {{8{imm8[7]}}, imm8};

  always_comb begin
    case (p_idx)
      ebcpu_pkg::PAIR_BC: pair_rd = bc;
      ebcpu_pkg::PAIR_DE: pair_rd = de;
      ebcpu_pkg::PAIR_HL: pair_rd = hl;
      default:            pair_rd = sp_q;
    endcase
  end

  always_comb begin
    // Hold state unless the instruction writes it
    a_d       = a_q;
    flags_d   = flags_q;
    known     = 1'b1;
    take_jump = 1'b0;
    pc_len    = 2'd1;
    cycles    = ebcpu_pkg::CYC_NONE;
    access    = ebcpu_pkg::MEM_NONE;
    addr      = 16'h0000;
    wdata     = 8'h00;
    operand   = 8'h00;
    result8   = 8'h00;
    is_dec    = in_op_q[0];
    half      = 1'b0;
    pw_en     = 1'b0;
    pw_sel    = p_idx;
    pw_val    = 16'h0000;
    rw_en     = 1'b0;
    rw_sel    = r_idx;
    rw_val    = 8'h00;
    xor_res   = 8'h00;

    if (in_cb_q) begin
      if (in_op_q inside {[ebcpu_pkg::CB_BIT_FIRST:ebcpu_pkg::CB_BIT_LAST]}) begin
        // BIT n: Z from the inverted bit, N clear, H set, C kept
        if (src_idx == ebcpu_pkg::REG_MEM) begin
          operand = in_mrd_q;
          access  = ebcpu_pkg::MEM_READ;
          addr    = hl;
        end else begin
          operand = ebcpu_pkg::sel_reg(src_idx, a_q, b_q, c_q, d_q, e_q, h_q, l_q);
        end
        flags_d = {~operand[r_idx], 1'b0, 1'b1, flags_q[0]};
        cycles  = ebcpu_pkg::CYC_8;
        pc_len  = 2'd2;
      end else begin
        known = 1'b0;
      end
    end else if (in_op_q == ebcpu_pkg::OP_NOP || in_op_q == ebcpu_pkg::OP_HALT) begin
      cycles = ebcpu_pkg::CYC_4;
    end else if (in_op_q inside {ebcpu_pkg::OP_JR, ebcpu_pkg::OP_JR_NZ, ebcpu_pkg::OP_JR_Z,
                                 ebcpu_pkg::OP_JR_NC, ebcpu_pkg::OP_JR_C}) begin
      pc_len = 2'd2;
      case (in_op_q)
        ebcpu_pkg::OP_JR_NZ: take_jump = !flags_q[3];
        ebcpu_pkg::OP_JR_Z:  take_jump = flags_q[3];
        ebcpu_pkg::OP_JR_NC: take_jump = !flags_q[0];
        ebcpu_pkg::OP_JR_C:  take_jump = flags_q[0];
        default:             take_jump = 1'b1;
      endcase
      cycles = take_jump ? ebcpu_pkg::CYC_12 : ebcpu_pkg::CYC_8;
    end else if ((in_op_q & ebcpu_pkg::MASK_PAIR) == ebcpu_pkg::OP_LD_RR_D16) begin
      pw_en  = 1'b1;
      pw_val = in_imm_q;
      pc_len = 2'd3;
      cycles = ebcpu_pkg::CYC_12;
    end else if ((in_op_q & ebcpu_pkg::MASK_PAIR) == ebcpu_pkg::OP_INC_RR) begin
      pw_en  = 1'b1;
      pw_val = pair_rd + 16'd1;
      cycles = ebcpu_pkg::CYC_8;
    end else if ((in_op_q & ebcpu_pkg::MASK_PAIR) == ebcpu_pkg::OP_DEC_RR) begin
      pw_en  = 1'b1;
      pw_val = pair_rd - 16'd1;
      cycles = ebcpu_pkg::CYC_8;
    end else if ((in_op_q & ebcpu_pkg::MASK_PAIR) == ebcpu_pkg::OP_ST_RR_A) begin
      // Store A through BC, DE, HL+ or HL-
      access = ebcpu_pkg::MEM_WRITE;
      wdata  = a_q;
      cycles = ebcpu_pkg::CYC_8;
      pw_sel = ebcpu_pkg::PAIR_HL;
      case (p_idx)
        ebcpu_pkg::PAIR_BC: addr = bc;
        ebcpu_pkg::PAIR_DE: addr = de;
        ebcpu_pkg::PAIR_HL: begin
          addr   = hl;
          pw_en  = 1'b1;
          pw_val = hl + 16'd1;
        end
        default: begin
          addr   = hl;
          pw_en  = 1'b1;
          pw_val = hl - 16'd1;
        end
      endcase
    end else if ((in_op_q & ebcpu_pkg::MASK_INCDEC) == ebcpu_pkg::OP_INCDEC_R) begin
      if (r_idx == ebcpu_pkg::REG_MEM) begin
        operand = in_mrd_q;
        access  = ebcpu_pkg::MEM_READ_WRITE;
        addr    = hl;
        cycles  = ebcpu_pkg::CYC_12;
      end else begin
        operand = ebcpu_pkg::sel_reg(r_idx, a_q, b_q, c_q, d_q, e_q, h_q, l_q);
        cycles  = ebcpu_pkg::CYC_4;
      end
      // DEC borrows into bit 4 when the low nibble is zero
      if (is_dec) begin
        result8 = operand - 8'd1;
        half    = (operand[3:0] == 4'h0);
      end else begin
        result8 = operand + 8'd1;
        half    = (operand[3:0] == 4'hF);
      end
      flags_d = {(result8 == 8'h00), is_dec, half, flags_q[0]};
      if (r_idx == ebcpu_pkg::REG_MEM) begin
        wdata = result8;
      end else begin
        rw_en  = 1'b1;
        rw_val = result8;
      end
    end else if ((in_op_q & ebcpu_pkg::MASK_LD_R) == ebcpu_pkg::OP_LD_R_D8) begin
      pc_len = 2'd2;
      if (r_idx == ebcpu_pkg::REG_MEM) begin
        access = ebcpu_pkg::MEM_WRITE;
        addr   = hl;
        wdata  = imm8;
        cycles = ebcpu_pkg::CYC_12;
      end else begin
        rw_en  = 1'b1;
        rw_val = imm8;
        cycles = ebcpu_pkg::CYC_8;
      end
    end else if (in_op_q inside {[ebcpu_pkg::OP_XOR_FIRST:ebcpu_pkg::OP_XOR_LAST]}) begin
      if (src_idx == ebcpu_pkg::REG_MEM) begin
        operand = in_mrd_q;
        access  = ebcpu_pkg::MEM_READ;
        addr    = hl;
      end else begin
        operand = ebcpu_pkg::sel_reg(src_idx, a_q, b_q, c_q, d_q, e_q, h_q, l_q);
      end
      xor_res = a_q ^ operand;
      a_d     = xor_res;
      flags_d = {(xor_res == 8'h00), 3'b000};
      cycles  = ebcpu_pkg::CYC_4;
    end else if (in_op_q == ebcpu_pkg::OP_LDH_C_A) begin
      access = ebcpu_pkg::MEM_WRITE;
      addr   = ebcpu_pkg::IO_PAGE | {8'h00, c_q};
      wdata  = a_q;
      cycles = ebcpu_pkg::CYC_8;
    end else if (in_op_q == ebcpu_pkg::OP_LDH_A_C) begin
      access = ebcpu_pkg::MEM_READ;
      addr   = ebcpu_pkg::IO_PAGE | {8'h00, c_q};
      a_d    = in_mrd_q;
      cycles = ebcpu_pkg::CYC_8;
    end else begin
      known = 1'b0;
    end

    // An 8-bit write that targets A lands here; the others go below
    if (rw_en && rw_sel == ebcpu_pkg::REG_A) begin
      a_d = rw_val;
    end
  end

  // Apply register file writes
  always_comb begin
    b_d  = b_q;
    c_d  = c_q;
    d_d  = d_q;
    e_d  = e_q;
    h_d  = h_q;
    l_d  = l_q;
    sp_d = sp_q;
    if (pw_en) begin
      case (pw_sel)
        ebcpu_pkg::PAIR_BC: {b_d, c_d} = pw_val;
        ebcpu_pkg::PAIR_DE: {d_d, e_d} = pw_val;
        ebcpu_pkg::PAIR_HL: {h_d, l_d} = pw_val;
        default:            sp_d       = pw_val;
      endcase
    end
    if (rw_en) begin
      case (rw_sel)
        ebcpu_pkg::REG_B: b_d = rw_val;
        ebcpu_pkg::REG_C: c_d = rw_val;
        ebcpu_pkg::REG_D: d_d = rw_val;
        ebcpu_pkg::REG_E: e_d = rw_val;
        ebcpu_pkg::REG_H: h_d = rw_val;
        ebcpu_pkg::REG_L: l_d = rw_val;
        default:          ;
      endcase
    end
  end

  // Program counter: a taken relative jump lands at PC + 2 + r8
  always_comb begin
    if (!known) begin
      pc_d = pc_q;
    end else if (take_jump) begin
      pc_d = pc_q + 16'd2 + rel_off;
    end else begin
      pc_d = pc_q + {14'd0, pc_len};
    end
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      a_q         <= 8'h00;
      b_q         <= 8'h00;
      c_q         <= 8'h00;
      d_q         <= 8'h00;
      e_q         <= 8'h00;
      h_q         <= 8'h00;
      l_q         <= 8'h00;
      flags_q     <= 4'h0;
      sp_q        <= 16'h0000;
      pc_q        <= 16'h0000;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      // An unknown opcode computes the held values, so no extra qualifier
      if (advance) begin
        a_q     <= a_d;
        b_q     <= b_d;
        c_q     <= c_d;
        d_q     <= d_d;
        e_q     <= e_d;
        h_q     <= h_d;
        l_q     <= l_d;
        flags_q <= flags_d;
        sp_q    <= sp_d;
        pc_q    <= pc_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q  <= s_axis_tdata[7:0];
      in_imm_q <= s_axis_tdata[23:8];
      in_mrd_q <= s_axis_tdata[31:24];
      in_cb_q  <= s_axis_tuser;
    end
    if (advance) begin
      out_unknown_q <= !known;
      // Unknown opcode: no access, so address and write data drop to zero
      out_data_q <= {{(ebcpu_pkg::OUT_TDATA_W - ebcpu_pkg::O_USED){1'b0}},
                     (known && access[1]) ? wdata : 8'h00,
                     known ? addr : 16'h0000,
                     known ? access : ebcpu_pkg::MEM_NONE,
                     known ? cycles : ebcpu_pkg::CYC_NONE,
                     flags_d,
                     sp_d,
                     {h_d, l_d},
                     {d_d, e_d},
                     {b_d, c_d},
                     a_d,
                     pc_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_unknown_q;

endmodule

// File: design/ebcpu_checker.sv
// ----------------------------------------------------------------------------
// ebcpu_checker
// Port-level checks on the result stream of the 8-bit CPU execute block.
// ----------------------------------------------------------------------------
module ebcpu_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [ebcpu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  logic [3:0]  cyc;
  logic [1:0]  acc;
  logic [15:0] addr;
  logic [7:0]  wdata;

  assign cyc   = m_axis_tdata[ebcpu_pkg::O_CYC +: 4];
  assign acc   = m_axis_tdata[ebcpu_pkg::O_ACC +: 2];
  assign addr  = m_axis_tdata[ebcpu_pkg::O_ADDR +: 16];
  assign wdata = m_axis_tdata[ebcpu_pkg::O_WDATA +: 8];

  // Unknown opcodes report no timing and no memory traffic
  a_unknown_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (cyc == ebcpu_pkg::CYC_NONE && acc == ebcpu_pkg::MEM_NONE && addr == 16'h0000))
    else $error("unknown opcode result shows cycles or a memory access");

  // Implemented instructions report one of the nonzero cycle count constants
  a_known_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      (cyc == ebcpu_pkg::CYC_4 || cyc == ebcpu_pkg::CYC_8 || cyc == ebcpu_pkg::CYC_12))
    else $error("implemented instruction with an invalid cycle count");

  // Write data only with a write; no address without an access
  a_mem_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((acc[1] || wdata == 8'h00) && (acc != ebcpu_pkg::MEM_NONE || addr == 16'h0000)))
    else $error("memory fields inconsistent with the access kind");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind eight_bit_cpu_execute_subset ebcpu_checker u_ebcpu_checker (.*);
